### hw/rtl/bct_pkg.sv
// Shared constants, codes and control types for the bus cycle trace capture block.
package bct_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_BATCH  = 64;
  localparam int BATCH_W    = $clog2(MAX_BATCH + 1);
  localparam int SEQ_W      = 32;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ENTRY_W    = SEQ_W + ADDR_W + DATA_W + 1;

  localparam logic [DATA_W-1:0] STOP_OPCODE   = 8'hDB;
  localparam logic [SEQ_W-1:0]  DEFAULT_LIMIT = 32'd10000;

  localparam logic CAUSE_STOP  = 1'b0;
  localparam logic CAUSE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_ARM   = 2'd0,
    OP_BUS   = 2'd1,
    OP_POLL  = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ALU_INC = 2'd0,
    ALU_DEC = 2'd1,
    ALU_GE  = 2'd2
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_DISPATCH = 3'd1,
    S_BUS_CHK  = 3'd2,
    S_POP_RD   = 3'd3,
    S_POP_OUT  = 3'd4,
    S_REPORT   = 3'd5
  } state_t;

  typedef struct packed {
    logic start_acc;
    op_t  op;
    logic armed;
    logic fifo_empty;
    logic pop_last;
  } seq_stat_t;

  typedef struct packed {
    logic    busy;
    logic    latch;
    logic    arm;
    logic    abort;
    logic    cnt_inc;
    logic    bus_check;
    logic    pop_rd;
    logic    pop_out;
    logic    report;
    alu_op_t alu_op;
  } seq_ctrl_t;

endpackage

### hw/rtl/bct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/bct_alu.sv
// Shared 32-bit increment / decrement / compare unit.
module bct_alu (
  input  bct_pkg::alu_op_t          op,
  input  logic [bct_pkg::SEQ_W-1:0] a,
  input  logic [bct_pkg::SEQ_W-1:0] b,
  output logic [bct_pkg::SEQ_W-1:0] res,
  output logic                      ge
);

  always_comb begin
    res = a;
    ge  = 1'b0;
    unique case (op)
      bct_pkg::ALU_INC: res = a + 32'd1;
      bct_pkg::ALU_DEC: res = a - 32'd1;
      bct_pkg::ALU_GE:  ge  = (a >= b);
      default:          res = a;
    endcase
  end

endmodule

### hw/rtl/bct_seq.sv
// Sequencer: steps each request through dispatch, counter check, pop and report states.
module bct_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  bct_pkg::seq_stat_t stat,
  output bct_pkg::seq_ctrl_t ctrl
);

  bct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.busy = (state_r != bct_pkg::S_IDLE);
    ctrl.alu_op = bct_pkg::ALU_INC;
    unique case (state_r)
      bct_pkg::S_IDLE: begin
        if (stat.start_acc) begin
          ctrl.latch = 1'b1;
          state_nxt  = bct_pkg::S_DISPATCH;
        end
      end
      bct_pkg::S_DISPATCH: begin
        unique case (stat.op)
          bct_pkg::OP_ARM: begin
            ctrl.arm  = 1'b1;
            state_nxt = bct_pkg::S_IDLE;
          end
          bct_pkg::OP_ABORT: begin
            ctrl.abort = 1'b1;
            state_nxt  = bct_pkg::S_IDLE;
          end
          bct_pkg::OP_BUS: begin
            if (stat.armed) begin
              ctrl.cnt_inc = 1'b1;
              ctrl.alu_op  = bct_pkg::ALU_INC;
              state_nxt    = bct_pkg::S_BUS_CHK;
            end else begin
              state_nxt = bct_pkg::S_IDLE;
            end
          end
          bct_pkg::OP_POLL: begin
            state_nxt = stat.fifo_empty ? bct_pkg::S_REPORT : bct_pkg::S_POP_RD;
          end
          default: state_nxt = bct_pkg::S_IDLE;
        endcase
      end
      bct_pkg::S_BUS_CHK: begin
        ctrl.bus_check = 1'b1;
        ctrl.alu_op    = bct_pkg::ALU_GE;
        state_nxt      = bct_pkg::S_IDLE;
      end
      bct_pkg::S_POP_RD: begin
        ctrl.pop_rd = 1'b1;
        ctrl.alu_op = bct_pkg::ALU_DEC;
        state_nxt   = bct_pkg::S_POP_OUT;
      end
      bct_pkg::S_POP_OUT: begin
        ctrl.pop_out = 1'b1;
        state_nxt    = stat.pop_last ? bct_pkg::S_IDLE : bct_pkg::S_POP_RD;
      end
      bct_pkg::S_REPORT: begin
        ctrl.report = 1'b1;
        state_nxt   = bct_pkg::S_IDLE;
      end
      default: state_nxt = bct_pkg::S_IDLE;
    endcase
  end

endmodule

### hw/rtl/bus_cycle_trace_capture.sv
// Top level of the bus cycle trace capture block: sample FIFO, counters, result register.
// Arm, abort and a disarmed bus cycle hold busy for the dispatch state only; an armed bus
// cycle holds it for dispatch (counter step), then check (limit compare and FIFO write).
// Poll: each sample takes a RAM read state, then an output state into the result register;
// an empty-FIFO poll passes the report state and strobes done/nothing.
// Sync reset empties FIFO, disarms, clears counter/done, limit = 10000; no output stall.
module bus_cycle_trace_capture (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_bus_data,
  input  logic        in_read_sense,
  input  logic [6:0]  in_poll_count,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_sequence_res,
  output logic [15:0] out_cycle_address,
  output logic [7:0]  out_cycle_data,
  output logic        out_cycle_write,
  output logic        out_stop_reason,
  output logic        out_capture_armed,
  output logic        out_last_of_run
);

  localparam int PTR_W   = bct_pkg::PTR_W;
  localparam int CNT_W   = bct_pkg::CNT_W;
  localparam int BATCH_W = bct_pkg::BATCH_W;
  localparam int SEQ_W   = bct_pkg::SEQ_W;
  localparam int ADDR_W  = bct_pkg::ADDR_W;
  localparam int DATA_W  = bct_pkg::DATA_W;

  bct_pkg::seq_stat_t stat;
  bct_pkg::seq_ctrl_t ctrl;

  // Latched request
  bct_pkg::op_t        op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   data_r;
  logic                rd_r;
  logic [BATCH_W-1:0]  remain_r, remain_nxt;

  // Capture state
  logic [SEQ_W-1:0]    cycle_limit_r;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                armed_r, armed_nxt;
  logic [SEQ_W-1:0]    counter_r, counter_nxt;
  logic                done_pend_r, done_pend_nxt;
  logic                done_cause_r, done_cause_nxt;
  logic [ADDR_W-1:0]   done_addr_r, done_addr_nxt;

  // Result register
  logic                out_valid_r;
  bct_pkg::kind_t      kind_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic [DATA_W-1:0]   res_data_r;
  logic                res_wr_r;
  logic                res_why_r;
  logic                res_armed_r;
  logic                res_last_r;

  // Shared unit and FIFO RAM
  logic [SEQ_W-1:0]    limit;
  logic [SEQ_W-1:0]    alu_a;
  logic [SEQ_W-1:0]    alu_res;
  logic                alu_ge;
  logic                ram_we;
  logic [bct_pkg::ENTRY_W-1:0] ram_wdata;
  logic [bct_pkg::ENTRY_W-1:0] ram_rdata;
  logic [BATCH_W-1:0]  batch;
  logic                stop_hit;

  // Zero in the register means the default limit
  assign limit = (cycle_limit_r == '0) ? bct_pkg::DEFAULT_LIMIT : cycle_limit_r;

  // Poll size: zero pops one, large values clamp to the batch limit
  always_comb begin
    if (in_poll_count == 7'd0) begin
      batch = BATCH_W'(1);
    end else if (in_poll_count > 7'(bct_pkg::MAX_BATCH)) begin
      batch = BATCH_W'(bct_pkg::MAX_BATCH);
    end else begin
      batch = BATCH_W'(in_poll_count);
    end
  end

  assign stat.start_acc  = start && !busy;
  assign stat.op         = op_r;
  assign stat.armed      = armed_r;
  assign stat.fifo_empty = (count_r == '0);
  // Counts already stepped down by the read cycle
  assign stat.pop_last   = (remain_r == '0) || (count_r == '0);

  bct_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Counter increment, limit compare and batch decrement share one unit
  assign alu_a = (ctrl.alu_op == bct_pkg::ALU_DEC) ? SEQ_W'(remain_r) : counter_r;

  bct_alu u_alu (
    .op  (ctrl.alu_op),
    .a   (alu_a),
    .b   (limit),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign ram_we    = ctrl.bus_check && (count_r < CNT_W'(bct_pkg::FIFO_DEPTH));
  assign ram_wdata = {counter_r, addr_r, data_r, ~rd_r};
  assign stop_hit  = rd_r && (data_r == bct_pkg::STOP_OPCODE);

  bct_ram #(
    .WIDTH (bct_pkg::ENTRY_W),
    .DEPTH (bct_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (ram_wdata),
    .rd_en   (ctrl.pop_rd),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  // Request latch
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      op_r   <= bct_pkg::op_t'(in_opcode);
      addr_r <= in_bus_address;
      data_r <= in_bus_data;
      rd_r   <= in_read_sense;
    end
  end

  // Capture state next values
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    armed_nxt      = armed_r;
    counter_nxt    = counter_r;
    done_pend_nxt  = done_pend_r;
    done_cause_nxt = done_cause_r;
    done_addr_nxt  = done_addr_r;
    remain_nxt     = remain_r;

    if (ctrl.latch) begin
      remain_nxt = batch;
    end

    if (ctrl.arm || ctrl.abort) begin
      head_nxt       = '0;
      tail_nxt       = '0;
      count_nxt      = '0;
      done_pend_nxt  = 1'b0;
      done_cause_nxt = bct_pkg::CAUSE_STOP;
      done_addr_nxt  = '0;
      armed_nxt      = ctrl.arm;
      // abort keeps the counter
      if (ctrl.arm) begin
        counter_nxt = '0;
      end
    end

    if (ctrl.cnt_inc) begin
      counter_nxt = alu_res;
    end

    if (ctrl.bus_check) begin
      if (ram_we) begin
        tail_nxt  = (tail_r == PTR_W'(bct_pkg::FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_nxt = count_r + 1'b1;
      end
      if (stop_hit || alu_ge) begin
        armed_nxt      = 1'b0;
        done_pend_nxt  = 1'b1;
        done_cause_nxt = stop_hit ? bct_pkg::CAUSE_STOP : bct_pkg::CAUSE_LIMIT;
        done_addr_nxt  = addr_r;
      end
    end

    if (ctrl.pop_rd) begin
      head_nxt   = (head_r == PTR_W'(bct_pkg::FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt  = count_r - 1'b1;
      remain_nxt = alu_res[BATCH_W-1:0];
    end

    // done record goes out once
    if (ctrl.report) begin
      done_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_limit_r <= bct_pkg::DEFAULT_LIMIT;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      armed_r       <= 1'b0;
      counter_r     <= '0;
      done_pend_r   <= 1'b0;
      done_cause_r  <= bct_pkg::CAUSE_STOP;
      done_addr_r   <= '0;
      remain_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cycle_limit_r <= cfg_wr_data;
      end
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      armed_r      <= armed_nxt;
      counter_r    <= counter_nxt;
      done_pend_r  <= done_pend_nxt;
      done_cause_r <= done_cause_nxt;
      done_addr_r  <= done_addr_nxt;
      remain_r     <= remain_nxt;
    end
  end

  // Result register: one strobe per popped sample or status report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.pop_out || ctrl.report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop_out) begin
      kind_r      <= bct_pkg::KIND_SAMPLE;
      seq_r       <= ram_rdata[bct_pkg::ENTRY_W-1 -: SEQ_W];
      res_addr_r  <= ram_rdata[DATA_W+1 +: ADDR_W];
      res_data_r  <= ram_rdata[1 +: DATA_W];
      res_wr_r    <= ram_rdata[0];
      res_why_r   <= 1'b0;
      res_armed_r <= 1'b0;
      res_last_r  <= stat.pop_last;
    end else if (ctrl.report) begin
      res_data_r  <= '0;
      res_wr_r    <= 1'b0;
      res_last_r  <= 1'b1;
      if (done_pend_r) begin
        kind_r      <= bct_pkg::KIND_DONE;
        seq_r       <= counter_r;
        res_addr_r  <= done_addr_r;
        res_why_r   <= done_cause_r;
        res_armed_r <= 1'b0;
      end else begin
        kind_r      <= bct_pkg::KIND_NONE;
        seq_r       <= '0;
        res_addr_r  <= '0;
        res_why_r   <= 1'b0;
        res_armed_r <= armed_r;
      end
    end
  end

  assign busy              = ctrl.busy;
  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_sequence_res  = seq_r;
  assign out_cycle_address = res_addr_r;
  assign out_cycle_data    = res_data_r;
  assign out_cycle_write   = res_wr_r;
  assign out_stop_reason   = res_why_r;
  assign out_capture_armed = res_armed_r;
  assign out_last_of_run   = res_last_r;

endmodule

### hw/rtl/bct_checker.sv
// Port-level checker for the trace capture block, bound to the top level.
module bct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_kind,
  input logic        out_stop_reason,
  input logic        out_capture_armed,
  input logic        out_last_of_run
);

  // An accepted request raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // Results only follow a cycle of work
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  // Done and nothing results are always single and final
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != bct_pkg::KIND_SAMPLE) |-> out_last_of_run)
    else $error("status result not marked last");

  // Samples carry no done cause or armed flag
  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bct_pkg::KIND_SAMPLE) |-> !out_stop_reason && !out_capture_armed)
    else $error("sample result has status fields set");

endmodule

bind bus_cycle_trace_capture bct_checker u_bct_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_kind          (out_kind),
  .out_stop_reason   (out_stop_reason),
  .out_capture_armed (out_capture_armed),
  .out_last_of_run   (out_last_of_run)
);
